// ===== design/chst_pkg.sv =====
`default_nettype none

package chst_pkg;

  // Table geometry and node id space
  localparam int SLOT_COUNT   = 256;
  localparam int NODE_ID_BITS = 8;
  localparam int SLOT_BITS    = $clog2(SLOT_COUNT);
  localparam int NODE_CNT_W   = NODE_ID_BITS + 1;
  localparam int TAKE_W       = $clog2(SLOT_COUNT + 1);
  localparam int REM_W        = TAKE_W + NODE_CNT_W;
  localparam int DIV_CNT_W    = $clog2(TAKE_W + 1);

  localparam logic [SLOT_BITS-1:0]  SLOT_LAST  = SLOT_BITS'(SLOT_COUNT - 1);
  localparam logic [TAKE_W-1:0]     SLOT_TOTAL = TAKE_W'(SLOT_COUNT);
  localparam logic [DIV_CNT_W-1:0]  DIV_LAST   = DIV_CNT_W'(TAKE_W - 1);

  // Fixed field widths of the channels
  localparam int HASH_W   = 32;
  localparam int NODE_W   = 8;
  localparam int NODES_W  = 9;
  localparam int STATUS_W = 2;

  // Hash to slot: floor(h / STRIDE) as an exact multiply by a rounded-up
  // reciprocal followed by a right shift
  localparam logic [31:0] SLOT_STRIDE =
    32'(64'h0000_0000_FFFF_FFFF / 64'(SLOT_COUNT - 1));
  localparam int STRIDE_LOG = $clog2(SLOT_STRIDE);
  localparam logic [96:0] RECIP_WIDE =
    ((97'd1 << (32 + STRIDE_LOG)) + 97'(SLOT_STRIDE) - 97'd1) / 97'(SLOT_STRIDE);
  localparam int RECIP_W = 33;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);
  localparam int QUO_W  = SLOT_BITS + 1;
  localparam int PROD_W = HASH_W + RECIP_W + QUO_W;

  // Item kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_ADD    = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LK_RD,
    ST_LK_OUT,
    ST_FILL,
    ST_DIV,
    ST_SCAN,
    ST_ADD_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/chst_in_if.sv =====
`default_nettype none

interface chst_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [chst_pkg::HASH_W-1:0] hash_value;
  logic [chst_pkg::NODE_W-1:0] new_node;

  modport source (output valid, kind, hash_value, new_node, input ready);
  modport sink   (input valid, kind, hash_value, new_node, output ready);
endinterface

`default_nettype wire

// ===== design/chst_out_if.sv =====
`default_nettype none

interface chst_out_if;
  logic                          valid;
  logic                          ready;
  logic                          done_kind;
  logic [chst_pkg::NODE_W-1:0]   owner_node;
  logic [chst_pkg::NODES_W-1:0]  nodes_present;
  logic [chst_pkg::STATUS_W-1:0] status;

  modport source (output valid, done_kind, owner_node, nodes_present, status,
                  input ready);
  modport sink   (input valid, done_kind, owner_node, nodes_present, status,
                  output ready);
endinterface

`default_nettype wire

// ===== design/consistent_hash_slot_table.sv =====
// Lookup: the table read, then the output register; a new beat is taken only once
// the result is in the output register. Add: a rejected add goes straight to the
// output; the first add fills the table; later adds run TAKE_W divider steps, then
// per visited node a table scan, then write the output register.
// One item is in work at a time; a finished result waits in the output register
// while the next beat is taken. After reset a clearing pass over every slot runs first.
`default_nettype none

module consistent_hash_slot_table (
  input  wire         clk,
  input  wire         rst_n,
  chst_in_if.sink     in_chan,
  chst_out_if.source  out_chan
);

  // Slot table memory and its ports
  logic [chst_pkg::NODE_ID_BITS-1:0] slot_mem [chst_pkg::SLOT_COUNT];
  logic [chst_pkg::NODE_ID_BITS-1:0] rd_data_r;
  logic                              mem_we;
  logic [chst_pkg::SLOT_BITS-1:0]    mem_waddr;
  logic [chst_pkg::NODE_ID_BITS-1:0] mem_wdata;
  logic                              mem_re;
  logic [chst_pkg::SLOT_BITS-1:0]    mem_raddr;

  // Control and working registers
  chst_pkg::state_t                   state_r, state_nxt;
  logic [chst_pkg::SLOT_BITS-1:0]     iss_r, iss_nxt;
  logic                               iss_live_r, iss_live_nxt;
  logic                               chk_v_r, chk_v_nxt;
  logic [chst_pkg::SLOT_BITS-1:0]     chk_addr_r, chk_addr_nxt;
  logic [chst_pkg::NODE_ID_BITS-1:0]  id_r, id_nxt;
  logic [chst_pkg::SLOT_BITS-1:0]     idx_r, idx_nxt;
  logic [chst_pkg::NODE_CNT_W-1:0]    node_total_r, node_total_nxt;
  logic [chst_pkg::NODE_ID_BITS-1:0]  who_r, who_nxt;
  logic [chst_pkg::NODE_CNT_W-1:0]    misses_r, misses_nxt;
  logic [chst_pkg::TAKE_W-1:0]        quot_r, quot_nxt;
  logic [chst_pkg::REM_W-1:0]         rem_r, rem_nxt;
  logic [chst_pkg::DIV_CNT_W-1:0]     div_cnt_r, div_cnt_nxt;
  logic [chst_pkg::STATUS_W-1:0]      status_r, status_nxt;

  // Output register
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_kind_r, out_kind_nxt;
  logic [chst_pkg::NODE_W-1:0]        out_owner_r, out_owner_nxt;
  logic [chst_pkg::NODES_W-1:0]       out_nodes_r, out_nodes_nxt;
  logic [chst_pkg::STATUS_W-1:0]      out_status_r, out_status_nxt;

  // Datapath helpers
  logic                                   in_beat;
  logic                                   out_free;
  logic [chst_pkg::PROD_W-1:0]            prod;
  logic [chst_pkg::QUO_W-1:0]             quo;
  logic [chst_pkg::SLOT_BITS-1:0]         quo_sat;
  logic [chst_pkg::NODE_ID_BITS+7:0]      new_node_ext;
  logic [chst_pkg::NODE_ID_BITS+7:0]      owner_ext;
  logic [chst_pkg::NODE_CNT_W+8:0]        nodes_ext;
  logic [chst_pkg::NODE_CNT_W-1:0]        divisor;
  logic [chst_pkg::REM_W-1:0]             trial;
  logic                                   q_bit;
  logic [chst_pkg::TAKE_W-1:0]            quot_step;
  logic                                   hit;
  logic                                   scan_end;
  logic [chst_pkg::NODE_ID_BITS-1:0]      who_adv;
  logic [chst_pkg::NODE_CNT_W-1:0]        node_inc;

  assign in_chan.ready          = (state_r == chst_pkg::ST_IDLE);
  assign in_beat                = in_chan.valid && (state_r == chst_pkg::ST_IDLE);
  assign out_free               = !out_valid_r || out_chan.ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.done_kind     = out_kind_r;
  assign out_chan.owner_node    = out_owner_r;
  assign out_chan.nodes_present = out_nodes_r;
  assign out_chan.status        = out_status_r;

  // Hash to slot index, saturated to the last slot
  assign prod    = chst_pkg::PROD_W'(in_chan.hash_value) * chst_pkg::PROD_W'(chst_pkg::RECIP);
  assign quo     = prod[32 + chst_pkg::STRIDE_LOG +: chst_pkg::QUO_W];
  assign quo_sat = (quo > chst_pkg::QUO_W'(chst_pkg::SLOT_COUNT - 1)) ?
                   chst_pkg::SLOT_LAST : quo[chst_pkg::SLOT_BITS-1:0];

  // Width adaptation between node ids and fixed port fields
  assign new_node_ext = {{chst_pkg::NODE_ID_BITS{1'b0}}, in_chan.new_node};
  assign owner_ext    = {8'd0, rd_data_r};
  assign nodes_ext    = {9'd0, node_total_r};
  assign node_inc     = node_total_r + 1'b1;

  // Restoring divider step: SLOT_COUNT / (node_total + 1)
  assign divisor   = node_inc;
  assign trial     = {rem_r[chst_pkg::REM_W-2:0], quot_r[chst_pkg::TAKE_W-1]};
  assign q_bit     = (trial >= chst_pkg::REM_W'(divisor));
  assign quot_step = {quot_r[chst_pkg::TAKE_W-2:0], q_bit};

  // Scan compare on the read data of the previous cycle
  assign hit      = chk_v_r && (rd_data_r == who_r);
  assign scan_end = chk_v_r && (chk_addr_r == chst_pkg::SLOT_LAST);
  assign who_adv  = (chst_pkg::NODE_CNT_W'(who_r) + 1'b1 == node_total_r) ?
                    '0 : who_r + 1'b1;

  // Next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    iss_nxt        = iss_r;
    iss_live_nxt   = iss_live_r;
    chk_v_nxt      = chk_v_r;
    chk_addr_nxt   = chk_addr_r;
    id_nxt         = id_r;
    idx_nxt        = idx_r;
    node_total_nxt = node_total_r;
    who_nxt        = who_r;
    misses_nxt     = misses_r;
    quot_nxt       = quot_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_kind_nxt   = out_kind_r;
    out_owner_nxt  = out_owner_r;
    out_nodes_nxt  = out_nodes_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = iss_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = iss_r;

    case (state_r)
      chst_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (iss_r == chst_pkg::SLOT_LAST) begin
          iss_nxt   = '0;
          state_nxt = chst_pkg::ST_IDLE;
        end else begin
          iss_nxt = iss_r + 1'b1;
        end
      end

      chst_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (in_chan.kind == chst_pkg::KIND_LOOKUP) begin
            idx_nxt   = quo_sat;
            state_nxt = chst_pkg::ST_LK_RD;
          end else begin
            id_nxt = new_node_ext[chst_pkg::NODE_ID_BITS-1:0];
            if (node_total_r[chst_pkg::NODE_ID_BITS]) begin
              status_nxt = chst_pkg::STATUS_FULL;
              state_nxt  = chst_pkg::ST_ADD_DONE;
            end else if (node_total_r == '0) begin
              iss_nxt   = '0;
              state_nxt = chst_pkg::ST_FILL;
            end else begin
              quot_nxt    = chst_pkg::SLOT_TOTAL;
              rem_nxt     = '0;
              div_cnt_nxt = '0;
              state_nxt   = chst_pkg::ST_DIV;
            end
          end
        end
      end

      chst_pkg::ST_LK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r;
        state_nxt = chst_pkg::ST_LK_OUT;
      end

      chst_pkg::ST_LK_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = chst_pkg::KIND_LOOKUP;
          out_owner_nxt  = owner_ext[chst_pkg::NODE_W-1:0];
          out_nodes_nxt  = nodes_ext[chst_pkg::NODES_W-1:0];
          out_status_nxt = chst_pkg::STATUS_OK;
          state_nxt      = chst_pkg::ST_IDLE;
        end
      end

      // First node owns every slot
      chst_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = id_r;
        if (iss_r == chst_pkg::SLOT_LAST) begin
          iss_nxt        = '0;
          node_total_nxt = chst_pkg::NODE_CNT_W'(1);
          status_nxt     = chst_pkg::STATUS_OK;
          state_nxt      = chst_pkg::ST_ADD_DONE;
        end else begin
          iss_nxt = iss_r + 1'b1;
        end
      end

      // Share of slots for the new node, one quotient bit per cycle
      chst_pkg::ST_DIV: begin
        rem_nxt     = q_bit ? (trial - chst_pkg::REM_W'(divisor)) : trial;
        quot_nxt    = quot_step;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == chst_pkg::DIV_LAST) begin
          who_nxt      = '0;
          misses_nxt   = '0;
          iss_nxt      = '0;
          iss_live_nxt = 1'b1;
          chk_v_nxt    = 1'b0;
          if (quot_step == '0) begin
            node_total_nxt = node_inc;
            status_nxt     = chst_pkg::STATUS_OK;
            state_nxt      = chst_pkg::ST_ADD_DONE;
          end else begin
            state_nxt = chst_pkg::ST_SCAN;
          end
        end
      end

      // Find the lowest slot owned by the visited node, reads pipelined
      chst_pkg::ST_SCAN: begin
        mem_re       = iss_live_r;
        chk_v_nxt    = iss_live_r;
        chk_addr_nxt = iss_r;
        if (iss_live_r) begin
          iss_nxt      = iss_r + 1'b1;
          iss_live_nxt = (iss_r != chst_pkg::SLOT_LAST);
        end
        if (hit) begin
          mem_we       = 1'b1;
          mem_waddr    = chk_addr_r;
          mem_wdata    = id_r;
          misses_nxt   = '0;
          who_nxt      = who_adv;
          quot_nxt     = quot_r - 1'b1;
          iss_nxt      = '0;
          iss_live_nxt = 1'b1;
          chk_v_nxt    = 1'b0;
          if (quot_r == chst_pkg::TAKE_W'(1)) begin
            node_total_nxt = node_inc;
            status_nxt     = chst_pkg::STATUS_OK;
            state_nxt      = chst_pkg::ST_ADD_DONE;
          end
        end else if (scan_end) begin
          if (misses_r + 1'b1 >= node_total_r) begin
            node_total_nxt = node_inc;
            status_nxt     = chst_pkg::STATUS_NO_SLOT;
            state_nxt      = chst_pkg::ST_ADD_DONE;
          end else begin
            misses_nxt   = misses_r + 1'b1;
            who_nxt      = who_adv;
            iss_nxt      = '0;
            iss_live_nxt = 1'b1;
            chk_v_nxt    = 1'b0;
          end
        end
      end

      chst_pkg::ST_ADD_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = chst_pkg::KIND_ADD;
          out_owner_nxt  = '0;
          out_nodes_nxt  = nodes_ext[chst_pkg::NODES_W-1:0];
          out_status_nxt = status_r;
          state_nxt      = chst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = chst_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= chst_pkg::ST_CLEAR;
      iss_r        <= '0;
      iss_live_r   <= 1'b0;
      chk_v_r      <= 1'b0;
      node_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      iss_r        <= iss_nxt;
      iss_live_r   <= iss_live_nxt;
      chk_v_r      <= chk_v_nxt;
      node_total_r <= node_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    chk_addr_r   <= chk_addr_nxt;
    id_r         <= id_nxt;
    idx_r        <= idx_nxt;
    who_r        <= who_nxt;
    misses_r     <= misses_nxt;
    quot_r       <= quot_nxt;
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    status_r     <= status_nxt;
    out_kind_r   <= out_kind_nxt;
    out_owner_r  <= out_owner_nxt;
    out_nodes_r  <= out_nodes_nxt;
    out_status_r <= out_status_nxt;
  end

  // Slot table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= slot_mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire
